### hdl/btts_pkg.sv
//------------------------------------------------------------------------------
// Binary and ternary table search package
// Widths, limits and small arithmetic helpers shared by the search block.
//------------------------------------------------------------------------------
`default_nettype none

package btts_pkg;

    localparam int DEPTH_DEFAULT = 1024;

    localparam int DATA_W  = 32;
    localparam int IDX_W   = 10;
    localparam int SIZE_W  = 11;
    localparam int CNT_W   = 6;
    localparam int POS_W   = SIZE_W + 1;

    localparam int S_TDATA_W = ((IDX_W + DATA_W + 7) / 8) * 8;
    localparam int M_RAW_W   = 2 * (1 + IDX_W + CNT_W);
    localparam int M_TDATA_W = ((M_RAW_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [0:0] OP_WRITE  = 1'b0;
    localparam logic [0:0] OP_SEARCH = 1'b1;

    // Reciprocal of three scaled by 2^11; exact floor for every value below 2047.
    localparam int               DIV3_SHIFT = SIZE_W;
    localparam logic [SIZE_W-2:0] DIV3_RECIP = 10'd683;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic [CNT_W-1:0]        cnt_t;

    function automatic logic [SIZE_W-1:0] div3(input logic [SIZE_W-1:0] x);
        logic [2*SIZE_W-2:0] prod;
        prod = (2*SIZE_W-1)'(x) * (2*SIZE_W-1)'(DIV3_RECIP);
        return SIZE_W'(prod >> DIV3_SHIFT);
    endfunction

    function automatic cnt_t cnt_add(input cnt_t c, input logic [1:0] inc);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(c) + (CNT_W+1)'(inc);
        return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hdl/binary_ternary_table_search.sv
//------------------------------------------------------------------------------
// Binary and ternary table search
// Sorted value store with a sequenced binary search followed by a ternary search.
//------------------------------------------------------------------------------
// A write transfer (tuser low) stores one value. A search transfer (tuser
// high) runs a binary search and then a ternary search over entries 0 to
// array_size-1, clipped to DEPTH, through one registered memory read port and
// one shared comparator. Each binary probe passes through S_BIN_ADDR and
// S_BIN_CMP, each ternary step through S_TER_ADDR1, S_TER_ADDR2 and S_TER_CMP;
// a search that ends without a match closes in its address state, and S_DONE
// loads the result register. The input is not ready while a search runs;
// a finished result waits in the output register while new transfers arrive.
`default_nettype none

module binary_ternary_table_search #(
    parameter int DEPTH = btts_pkg::DEPTH_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wen,
    input  wire logic [btts_pkg::SIZE_W-1:0]    cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // entry_index[9:0], value[41:10], zero fill above
    input  wire logic [btts_pkg::S_TDATA_W-1:0] s_tdata,
    // operation[0]
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // bin_found[0], bin_index[10:1], bin_compares[16:11],
    // ter_found[17], ter_index[27:18], ter_compares[33:28], zero fill above
    output logic [btts_pkg::M_TDATA_W-1:0]      m_tdata
);
    import btts_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_BIN_ADDR  = 7'b0000010,
        S_BIN_CMP   = 7'b0000100,
        S_TER_ADDR1 = 7'b0001000,
        S_TER_ADDR2 = 7'b0010000,
        S_TER_CMP   = 7'b0100000,
        S_DONE      = 7'b1000000
    } state_t;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic [AW-1:0]            rd_addr;

    state_t state_reg, state_next;
    logic [SIZE_W-1:0] array_size_reg;
    logic              out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic signed [DATA_W-1:0] key_reg, key_next;
    pos_t lo_reg, lo_next, hi_reg, hi_next, n_reg, n_next;
    pos_t m1_reg, m1_next, m2_reg, m2_next;
    cnt_t cnt_reg, cnt_next;
    logic e1_gt_reg, e1_gt_next;
    logic bin_found_reg, bin_found_next;
    logic [IDX_W-1:0] bin_index_reg, bin_index_next;
    cnt_t bin_cnt_reg, bin_cnt_next;
    logic ter_found_reg, ter_found_next;
    logic [IDX_W-1:0] ter_index_reg, ter_index_next;

    logic [0:0]               in_op;
    logic [IDX_W-1:0]         in_index;
    logic signed [DATA_W-1:0] in_value;
    logic                     in_xfer;
    logic                     wr_en;
    pos_t                     n_clip;

    logic cmp_eq, cmp_key_lt, cmp_key_gt;
    pos_t mid, diff, m1, m2;
    logic [SIZE_W-1:0] third;

    assign in_op    = s_tuser;
    assign in_index = s_tdata[IDX_W-1:0];
    assign in_value = s_tdata[IDX_W+DATA_W-1:IDX_W];
    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign wr_en    = in_xfer && (in_op == OP_WRITE) && (32'(in_index) < DEPTH);
    assign n_clip   = (32'(array_size_reg) > DEPTH) ? POS_W'(DEPTH)
                                                    : POS_W'(array_size_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Shared comparator: the registered memory word against the key.
    assign cmp_eq     = (rd_data_reg == key_reg);
    assign cmp_key_lt = (key_reg < rd_data_reg);
    assign cmp_key_gt = (key_reg > rd_data_reg);

    assign diff  = hi_reg - lo_reg;
    assign mid   = lo_reg + (diff >>> 1);
    assign third = div3(diff[SIZE_W-1:0]);
    assign m1    = lo_reg + POS_W'(third);
    assign m2    = hi_reg - POS_W'(third);

    always_comb
    begin
        case (state_reg)
            S_BIN_ADDR:  rd_addr = AW'(mid[POS_W-2:0]);
            S_TER_ADDR1: rd_addr = AW'(m1[POS_W-2:0]);
            S_TER_ADDR2: rd_addr = AW'(m2_reg[POS_W-2:0]);
            default:     rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[AW'(in_index)] <= in_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        key_next       = key_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        n_next         = n_reg;
        m1_next        = m1_reg;
        m2_next        = m2_reg;
        cnt_next       = cnt_reg;
        e1_gt_next     = e1_gt_reg;
        bin_found_next = bin_found_reg;
        bin_index_next = bin_index_reg;
        bin_cnt_next   = bin_cnt_reg;
        ter_found_next = ter_found_reg;
        ter_index_next = ter_index_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (in_op == OP_SEARCH))
                begin
                    key_next       = in_value;
                    n_next         = n_clip;
                    lo_next        = '0;
                    hi_next        = n_clip - POS_W'(1);
                    cnt_next       = '0;
                    bin_found_next = 1'b0;
                    bin_index_next = '0;
                    state_next     = S_BIN_ADDR;
                end
            end
            S_BIN_ADDR:
            begin
                if (lo_reg > hi_reg)
                begin
                    bin_cnt_next   = cnt_reg;
                    cnt_next       = '0;
                    lo_next        = '0;
                    hi_next        = n_reg - POS_W'(1);
                    ter_found_next = 1'b0;
                    ter_index_next = '0;
                    state_next     = S_TER_ADDR1;
                end
                else
                begin
                    m1_next    = mid;
                    state_next = S_BIN_CMP;
                end
            end
            S_BIN_CMP:
            begin
                if (cmp_eq)
                begin
                    bin_found_next = 1'b1;
                    bin_index_next = IDX_W'(m1_reg);
                    bin_cnt_next   = cnt_add(cnt_reg, 2'd1);
                    cnt_next       = '0;
                    lo_next        = '0;
                    hi_next        = n_reg - POS_W'(1);
                    ter_found_next = 1'b0;
                    ter_index_next = '0;
                    state_next     = S_TER_ADDR1;
                end
                else
                begin
                    cnt_next = cnt_add(cnt_reg, 2'd2);
                    if (cmp_key_lt)
                    begin
                        hi_next = m1_reg - POS_W'(1);
                    end
                    else
                    begin
                        lo_next = m1_reg + POS_W'(1);
                    end
                    state_next = S_BIN_ADDR;
                end
            end
            S_TER_ADDR1:
            begin
                if (lo_reg > hi_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    m1_next    = m1;
                    m2_next    = m2;
                    state_next = S_TER_ADDR2;
                end
            end
            S_TER_ADDR2:
            begin
                cnt_next = cnt_add(cnt_reg, 2'd1);
                if (cmp_eq)
                begin
                    ter_found_next = 1'b1;
                    ter_index_next = IDX_W'(m1_reg);
                    state_next     = S_DONE;
                end
                else
                begin
                    e1_gt_next = cmp_key_lt;
                    state_next = S_TER_CMP;
                end
            end
            S_TER_CMP:
            begin
                state_next = S_TER_ADDR1;
                if (cmp_eq)
                begin
                    cnt_next       = cnt_add(cnt_reg, 2'd1);
                    ter_found_next = 1'b1;
                    ter_index_next = IDX_W'(m2_reg);
                    state_next     = S_DONE;
                end
                else if (e1_gt_reg)
                begin
                    cnt_next = cnt_add(cnt_reg, 2'd2);
                    hi_next  = m1_reg - POS_W'(1);
                end
                else
                begin
                    cnt_next = cnt_add(cnt_reg, 2'd3);
                    if (cmp_key_gt)
                    begin
                        lo_next = m2_reg + POS_W'(1);
                    end
                    else
                    begin
                        lo_next = m1_reg + POS_W'(1);
                        hi_next = m2_reg - POS_W'(1);
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = M_TDATA_W'({cnt_reg, ter_index_reg, ter_found_reg,
                                                 bin_cnt_reg, bin_index_reg, bin_found_reg});
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            array_size_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
            begin
                array_size_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        key_reg       <= key_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        n_reg         <= n_next;
        m1_reg        <= m1_next;
        m2_reg        <= m2_next;
        cnt_reg       <= cnt_next;
        e1_gt_reg     <= e1_gt_next;
        bin_found_reg <= bin_found_next;
        bin_index_reg <= bin_index_next;
        bin_cnt_reg   <= bin_cnt_next;
        ter_found_reg <= ter_found_next;
        ter_index_reg <= ter_index_next;
    end

endmodule

`default_nettype wire

### tb/binary_ternary_table_search_tb.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Binary and ternary table search testbench
// Streams table writes and key searches into the block under random flow
// control, predicts the result of both searches for every accepted search
// transfer and compares each output transfer field by field, in order.
//------------------------------------------------------------------------------

module binary_ternary_table_search_tb;

    import btts_pkg::*;

    localparam int     TABLE_DEPTH   = DEPTH_DEFAULT;
    localparam int     ITEM_TARGET   = 1950;
    localparam int     DRAIN_CYCLES  = 80;
    localparam int     HOLD_CYCLES   = 300;
    localparam longint TIMEOUT_NS    = 64'd10_000_000;
    localparam longint MIN_VAL       = -64'sd2147483648;
    localparam longint MAX_VAL       = 64'sd2147483647;
    localparam int     REPORT_LIMIT  = 100;

    typedef logic signed [DATA_W-1:0] value_t;

    typedef struct {
        logic [0:0]       op;
        logic [IDX_W-1:0] index;
        value_t           value;
    } table_op_t;

    typedef struct {
        logic             bin_found;
        logic [IDX_W-1:0] bin_index;
        logic [CNT_W-1:0] bin_compares;
        logic             ter_found;
        logic [IDX_W-1:0] ter_index;
        logic [CNT_W-1:0] ter_compares;
    } lookup_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wen = 1'b0;
    logic [SIZE_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    table_op_t      queued_ops[$];
    lookup_result_t expected_lookups[$];
    table_op_t      next_op;
    value_t         stored_vals[TABLE_DEPTH];
    value_t         planned_vals[TABLE_DEPTH];
    logic [SIZE_W-1:0] active_size = '0;
    int             planned_size = 0;
    int             items_pushed = 0;
    int             error_count = 0;
    int             tx_idle_pct = 0;
    int             rx_stall_pct = 0;
    logic           in_fire = 1'b0;
    logic           hold_start = 1'b0;
    int             hold_left = 0;

    binary_ternary_table_search dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic lookup_result_t predict_lookup(input value_t key);
        lookup_result_t res;
        int             n;
        int             lo;
        int             hi;
        int             mid;
        int             third;
        int             m1;
        int             m2;
        int             cmp;
        int             pos;
        logic           hit;
        value_t         e;
        value_t         e1;
        value_t         e2;
        n = (active_size > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_size);

        lo = 0;
        hi = n - 1;
        cmp = 0;
        pos = 0;
        hit = 1'b0;
        while (!hit && lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            e = stored_vals[mid];
            cmp++;
            if (e == key)
            begin
                hit = 1'b1;
                pos = mid;
            end
            else
            begin
                cmp++;
                if (key < e)
                    hi = mid - 1;
                else
                    lo = mid + 1;
            end
        end
        res.bin_found    = hit;
        res.bin_index    = hit ? IDX_W'(pos) : '0;
        res.bin_compares = (cmp > int'(CNT_MAX)) ? CNT_MAX : CNT_W'(cmp);

        lo = 0;
        hi = n - 1;
        cmp = 0;
        pos = 0;
        hit = 1'b0;
        while (!hit && lo <= hi)
        begin
            third = (hi - lo) / 3;
            m1 = lo + third;
            m2 = hi - third;
            e1 = stored_vals[m1];
            e2 = stored_vals[m2];
            cmp++;
            if (e1 == key)
            begin
                hit = 1'b1;
                pos = m1;
            end
            else
            begin
                cmp++;
                if (e2 == key)
                begin
                    hit = 1'b1;
                    pos = m2;
                end
                else
                begin
                    cmp++;
                    if (e1 > key)
                        hi = m1 - 1;
                    else
                    begin
                        cmp++;
                        if (e2 < key)
                            lo = m2 + 1;
                        else
                        begin
                            lo = m1 + 1;
                            hi = m2 - 1;
                        end
                    end
                end
            end
        end
        res.ter_found    = hit;
        res.ter_index    = hit ? IDX_W'(pos) : '0;
        res.ter_compares = (cmp > int'(CNT_MAX)) ? CNT_MAX : CNT_W'(cmp);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // Predictor and scoreboard share one block so that pushes and pops of the
    // expected results never race within a time step.
    always @(posedge clk)
    begin
        lookup_result_t want;
        in_fire <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (cfg_wen)
                active_size = cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == OP_WRITE)
                    stored_vals[s_tdata[IDX_W-1:0]] = s_tdata[IDX_W +: DATA_W];
                else
                    expected_lookups.push_back(predict_lookup(s_tdata[IDX_W +: DATA_W]));
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_lookups.size() == 0)
                    report_mismatch("result transfer with no search outstanding");
                else
                begin
                    want = expected_lookups.pop_front();
                    check_field("bin_found", m_tdata[0], want.bin_found);
                    check_field("bin_index", m_tdata[10:1], want.bin_index);
                    check_field("bin_compares", m_tdata[16:11], want.bin_compares);
                    check_field("ter_found", m_tdata[17], want.ter_found);
                    check_field("ter_index", m_tdata[27:18], want.ter_index);
                    check_field("ter_compares", m_tdata[33:28], want.ter_compares);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_fire))
        begin
            if (queued_ops.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                next_op = queued_ops.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_op.op;
                s_tdata  <= S_TDATA_W'({next_op.value, next_op.index});
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
        m_tready <= rst_n && (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);

    always @(posedge clk)
    begin
        if (hold_start)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    function automatic longint rand_between(input longint lo, input longint hi);
        longint span;
        span = hi - lo + 1;
        return lo + longint'({$urandom, $urandom} % span);
    endfunction

    task automatic push_write(input int idx, input longint v);
        table_op_t t;
        t.op    = OP_WRITE;
        t.index = IDX_W'(idx);
        t.value = value_t'(v);
        planned_vals[idx] = t.value;
        queued_ops.push_back(t);
        items_pushed++;
    endtask

    task automatic push_search(input value_t key);
        table_op_t t;
        t.op    = OP_SEARCH;
        t.index = IDX_W'($urandom);
        t.value = key;
        queued_ops.push_back(t);
        items_pushed++;
    endtask

    function automatic value_t pick_key(input int n);
        int r;
        r = $urandom_range(99);
        if (n > 0 && r < 60)
            return planned_vals[$urandom_range(n - 1)];
        else if (n > 0 && r < 75)
            return planned_vals[$urandom_range(n - 1)] + ($urandom_range(1) ? 1 : -1);
        else if (r < 85)
            return $urandom_range(1) ? value_t'(MAX_VAL) : value_t'(MIN_VAL);
        return value_t'($urandom);
    endfunction

    // Rewrites entries 0..count-1, in random order, with ascending values all
    // no larger than the entry above them, so that the whole table stays sorted.
    task automatic rebuild_sorted(input int count);
        int     vals[$];
        int     order[$];
        longint lo;
        longint hi;
        lo = MIN_VAL;
        hi = (count < TABLE_DEPTH) ? longint'(planned_vals[count]) : MAX_VAL;
        if ($urandom_range(3) == 0 && hi - lo > 2 * count + 2)
        begin
            lo = rand_between(lo, hi - 2 * count - 2);
            hi = lo + 2 * count + 2;
        end
        for (int i = 0; i < count; i++)
        begin
            vals.push_back(int'(rand_between(lo, hi)));
            order.push_back(i);
        end
        vals.sort();
        order.shuffle();
        foreach (order[k])
            push_write(order[k], vals[order[k]]);
    endtask

    task automatic nudge_entry(input int n);
        int     idx;
        longint lo;
        longint hi;
        idx = $urandom_range(n - 1);
        lo = (idx > 0) ? longint'(planned_vals[idx - 1]) : MIN_VAL;
        hi = (idx < TABLE_DEPTH - 1) ? longint'(planned_vals[idx + 1]) : MAX_VAL;
        push_write(idx, rand_between(lo, hi));
    endtask

    task automatic wait_idle();
        while (queued_ops.size() != 0 || s_tvalid || expected_lookups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input int sz);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= SIZE_W'(sz);
        @(negedge clk);
        cfg_wen   <= 1'b0;
        planned_size = (sz > TABLE_DEPTH) ? TABLE_DEPTH : sz;
    endtask

    initial
    begin
        int phase;
        int kind;
        int sz;
        int n;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty table straight out of reset.
        push_search('0);
        push_search(value_t'(MIN_VAL));
        push_search(value_t'(MAX_VAL));
        push_search(value_t'($urandom));

        // Fill the whole table in random order, with both extremes present.
        rebuild_sorted(TABLE_DEPTH);
        push_write(0, MIN_VAL);
        push_write(TABLE_DEPTH - 1, MAX_VAL);

        // Size register beyond the table depth.
        wait_idle();
        write_size((1 << SIZE_W) - 1);
        push_search(value_t'(MIN_VAL));
        push_search(value_t'(MAX_VAL));
        push_search(planned_vals[TABLE_DEPTH / 2]);
        push_search(planned_vals[1]);
        push_search(planned_vals[700] + 1);

        phase = 0;
        while (items_pushed < ITEM_TARGET)
        begin
            wait_idle();
            case (phase % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 71; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 71; end
                default: begin tx_idle_pct = 35; rx_stall_pct = 35; end
            endcase
            kind = phase % 5;
            if (kind == 0 || kind == 2 || kind == 3)
            begin
                case ($urandom_range(5))
                    0:       sz = 0;
                    1:       sz = 1;
                    2:       sz = 2;
                    3:       sz = 3;
                    default: sz = $urandom_range(4, 48);
                endcase
                if (kind == 3 && sz < 2)
                    sz = $urandom_range(2, 40);
            end
            else
            begin
                case ($urandom_range(4))
                    0:       sz = (1 << SIZE_W) - 1;
                    1:       sz = TABLE_DEPTH;
                    2:       sz = TABLE_DEPTH - 1;
                    3:       sz = $urandom_range(TABLE_DEPTH + 1, (1 << SIZE_W) - 2);
                    default: sz = $urandom_range(49, TABLE_DEPTH - 1);
                endcase
            end
            write_size(sz);
            n = planned_size;

            if (phase == 4)
            begin
                @(negedge clk);
                hold_start = 1'b1;
                @(negedge clk);
                hold_start = 1'b0;
            end

            case (kind)
                0, 2:
                begin
                    rebuild_sorted(n);
                    for (int i = 0; i < 40; i++)
                    begin
                        if (kind == 2 && n > 0 && $urandom_range(3) == 0)
                            nudge_entry(n);
                        push_search(pick_key(n));
                    end
                end
                3:
                begin
                    // Unsorted table: random values and copies of other entries.
                    for (int i = 0; i < n + 4; i++)
                    begin
                        if ($urandom_range(2) == 0)
                            push_write($urandom_range(n - 1), planned_vals[$urandom_range(n - 1)]);
                        else
                            push_write($urandom_range(n - 1), value_t'($urandom));
                        if ($urandom_range(1) == 0)
                            push_search(pick_key(n));
                    end
                    for (int i = 0; i < 30; i++)
                        push_search(pick_key(n));
                    rebuild_sorted(n);
                end
                default:
                begin
                    for (int i = 0; i < 45; i++)
                    begin
                        if (phase == 6 && i == 22)
                            wait_idle();
                        if ($urandom_range(7) == 0)
                            nudge_entry(n);
                        push_search(pick_key(n));
                    end
                end
            endcase
            phase++;
        end

        wait_idle();
        if (error_count == 0)
            $display("binary_ternary_table_search regression: pass");
        else
            $display("binary_ternary_table_search regression: fail");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("binary_ternary_table_search regression: fail");
        $finish;
    end

endmodule

### filelist.f
hdl/btts_pkg.sv
hdl/binary_ternary_table_search.sv
tb/binary_ternary_table_search_tb.sv
